@@ sv/rsnh_pkg.sv @@
// shared types and constants of the ray segment nearest hit block
package rsnh_pkg;

  localparam int COORD_W = 16;
  localparam int SLOT_W  = 6;
  localparam int CFG_W   = 7;
  localparam int OUT_W   = 24;
  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CROSS,
    ST_TEST,
    ST_NUM,
    ST_DSTART,
    ST_DIV,
    ST_DIST,
    ST_CMP,
    ST_NEXT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    ORI_COL,
    ORI_POS,
    ORI_NEG
  } ori_e;

  // multiply step sequence
  localparam logic [4:0] STEP_O1A  = 5'd0;
  localparam logic [4:0] STEP_O1B  = 5'd1;
  localparam logic [4:0] STEP_O2A  = 5'd2;
  localparam logic [4:0] STEP_O2B  = 5'd3;
  localparam logic [4:0] STEP_O3A  = 5'd4;
  localparam logic [4:0] STEP_O3B  = 5'd5;
  localparam logic [4:0] STEP_O4A  = 5'd6;
  localparam logic [4:0] STEP_O4B  = 5'd7;
  localparam logic [4:0] STEP_DOTA = 5'd8;
  localparam logic [4:0] STEP_DOTB = 5'd9;
  localparam logic [4:0] STEP_NSQA = 5'd10;
  localparam logic [4:0] STEP_NSQB = 5'd11;
  localparam logic [4:0] STEP_NUMX = 5'd12;
  localparam logic [4:0] STEP_NUMY = 5'd13;
  localparam logic [4:0] STEP_DXL  = 5'd14;
  localparam logic [4:0] STEP_DXH  = 5'd15;
  localparam logic [4:0] STEP_DYL  = 5'd16;
  localparam logic [4:0] STEP_DYH  = 5'd17;

endpackage

@@ sv/rsnh_if.sv @@
// handshake channel interfaces of the ray segment nearest hit block
interface rsnh_req_if;
  import rsnh_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [SLOT_W-1:0]         slot;
  logic signed [COORD_W-1:0] first_x;
  logic signed [COORD_W-1:0] first_y;
  logic signed [COORD_W-1:0] second_x;
  logic signed [COORD_W-1:0] second_y;
  modport source(output valid, op, slot, first_x, first_y, second_x, second_y, input ready);
  modport sink(input valid, op, slot, first_x, first_y, second_x, second_y, output ready);
endinterface

interface rsnh_rsp_if;
  import rsnh_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [OUT_W-1:0] near_x;
  logic signed [OUT_W-1:0] near_y;
  modport source(output valid, hit, near_x, near_y, input ready);
  modport sink(input valid, hit, near_x, near_y, output ready);
endinterface

interface rsnh_cfg_if;
  import rsnh_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

@@ sv/rsnh_div.sv @@
// bit-serial unsigned restoring divider, one quotient bit per cycle
module rsnh_div #(
  parameter int QW = 25,
  parameter int DW = 36
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [QW+DW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  output logic             busy_o,
  output logic [QW-1:0]    quo_o,
  output logic             rem_nz_o
);

  localparam int CW = $clog2(QW + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] sh_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   trial;
  logic          ge;

  always_comb begin
    trial = {rem_q, sh_q[QW-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(QW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[QW+DW-1:QW];
      sh_q  <= num_i[QW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[QW-2:0], ge};
    end
  end

  assign busy_o   = busy_q;
  assign quo_o    = sh_q;
  assign rem_nz_o = |rem_q;

endmodule

@@ sv/ray_segment_nearest_hit_core.sv @@
// top level: segment table, shared multiply sequencer and nearest hit search
// A load transfer writes one segment into the table when its slot is below
// MAX_SEGMENTS and gives no result. A query transfer walks the first
// min(segment_count, MAX_SEGMENTS) slots one after another through one
// 19x37 multiplier: a segment that is missed goes through the table read,
// twelve products for the four orientations, dot product and squared
// length, the test and the step; a segment that is hit inside its span is
// bound by the two bit-serial dividers, and a hit at an endpoint skips
// them. The query then hands over its result, which waits in an output
// register while the next transfer is taken.
module ray_segment_nearest_hit_core #(
  parameter int MAX_SEGMENTS = 64,
  parameter int FRAC_BITS    = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rsnh_req_if.sink   req_i,
  rsnh_rsp_if.source rsp_o,
  rsnh_cfg_if.sink   cfg_i
);
  import rsnh_pkg::*;

  localparam int AW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNW  = AW + 1;
  localparam int NW   = (CNW > CFG_W) ? CNW : CFG_W;
  localparam int QW   = 17 + FRAC_BITS;
  localparam int DW   = 36;
  localparam int CW   = (FRAC_BITS + 18 > 25) ? FRAC_BITS + 18 : 25;
  localparam int DXW  = 19 + FRAC_BITS;
  localparam int D2W  = 2 * (18 + FRAC_BITS) + 3;
  localparam int MAW  = 19;
  localparam int MBW  = 37;
  localparam int PW   = MAW + MBW;
  localparam int NUMW = 54;
  localparam logic signed [CW-1:0] SAT_HI = CW'(OUT_MAX);
  localparam logic signed [CW-1:0] SAT_LO = CW'(OUT_MIN);

  state_e state_q, state_d;
  logic [4:0]     step_q;
  logic [CNW-1:0] cnt_q;
  logic [CFG_W-1:0] count_q;
  logic [NW-1:0]  n_seg;
  logic           req_ready, req_fire, div_start, more_seg;

  logic [63:0] mem [MAX_SEGMENTS];
  logic [63:0] rd_q;
  logic [AW+SLOT_W-1:0] slot_ext;

  logic signed [COORD_W-1:0] p_x_q, p_y_q, f_x_q, f_y_q;
  logic signed [COORD_W-1:0] a_x, a_y, b_x, b_y;
  logic signed [16:0] d_fy_py, d_px_fx, d_ax_fx, d_ay_fy, d_bx_fx, d_by_fy;
  logic signed [16:0] d_px_bx, d_py_by, d_fx_bx, d_fy_by, d_px_ax, d_py_ay;
  logic signed [16:0] abx, aby, bax;

  logic signed [MAW-1:0] op_a;
  logic signed [MBW-1:0] op_b;
  logic signed [PW-1:0]  prod;
  logic signed [36:0]    acc_q, cross_val, dot_q, nsq_q;
  ori_e                  ori_q [4];
  ori_e                  ori_new;
  logic                  seg_hit;

  logic signed [NUMW-1:0] num_x_q, num_y_q, neg_x, neg_y;
  logic [QW+DW-1:0]       dnum_x, dnum_y;
  logic                   busy_x, busy_y, rnz_x, rnz_y;
  logic [QW-1:0]          quo_x, quo_y;
  logic signed [CW-1:0]   qs_x, qs_y;

  logic signed [CW-1:0]  cx_q, cy_q, best_x_q, best_y_q;
  logic signed [DXW-1:0] dx, dy;
  logic [DXW-1:0]        m_x, m_y;
  logic signed [D2W-1:0] d2_q, best_d2_q, prod_w;
  logic                  best_hit_q;

  logic                    rsp_valid_q, rsp_valid_d, rsp_hit_q;
  logic signed [OUT_W-1:0] rsp_x_q, rsp_y_q, sat_x, sat_y;

  function automatic logic in_box(
    input logic signed [COORD_W-1:0] px, py, qx, qy, rx, ry
  );
    logic signed [COORD_W-1:0] hx, lx, hy, ly;
    hx = (px > rx) ? px : rx;
    lx = (px < rx) ? px : rx;
    hy = (py > ry) ? py : ry;
    ly = (py < ry) ? py : ry;
    return (qx <= hx) && (qx >= lx) && (qy <= hy) && (qy >= ly);
  endfunction

  // table entry and differences
  assign a_x = $signed(rd_q[15:0]);
  assign a_y = $signed(rd_q[31:16]);
  assign b_x = $signed(rd_q[47:32]);
  assign b_y = $signed(rd_q[63:48]);

  assign d_fy_py = 17'(f_y_q) - 17'(p_y_q);
  assign d_px_fx = 17'(p_x_q) - 17'(f_x_q);
  assign d_ax_fx = 17'(a_x) - 17'(f_x_q);
  assign d_ay_fy = 17'(a_y) - 17'(f_y_q);
  assign d_bx_fx = 17'(b_x) - 17'(f_x_q);
  assign d_by_fy = 17'(b_y) - 17'(f_y_q);
  assign d_px_bx = 17'(p_x_q) - 17'(b_x);
  assign d_py_by = 17'(p_y_q) - 17'(b_y);
  assign d_fx_bx = 17'(f_x_q) - 17'(b_x);
  assign d_fy_by = 17'(f_y_q) - 17'(b_y);
  assign d_px_ax = 17'(p_x_q) - 17'(a_x);
  assign d_py_ay = 17'(p_y_q) - 17'(a_y);
  assign abx     = 17'(b_x) - 17'(a_x);
  assign aby     = 17'(b_y) - 17'(a_y);
  assign bax     = 17'(a_x) - 17'(b_x);

  // distance magnitudes
  assign dx  = DXW'(cx_q) - (DXW'(p_x_q) <<< FRAC_BITS);
  assign dy  = DXW'(cy_q) - (DXW'(p_y_q) <<< FRAC_BITS);
  assign m_x = dx[DXW-1] ? DXW'(-dx) : DXW'(dx);
  assign m_y = dy[DXW-1] ? DXW'(-dy) : DXW'(dy);

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step_q)
      STEP_O1A:  begin op_a = MAW'(d_fy_py); op_b = MBW'(d_ax_fx); end
      STEP_O1B:  begin op_a = MAW'(d_px_fx); op_b = MBW'(d_ay_fy); end
      STEP_O2A:  begin op_a = MAW'(d_fy_py); op_b = MBW'(d_bx_fx); end
      STEP_O2B:  begin op_a = MAW'(d_px_fx); op_b = MBW'(d_by_fy); end
      STEP_O3A:  begin op_a = MAW'(aby);     op_b = MBW'(d_px_bx); end
      STEP_O3B:  begin op_a = MAW'(bax);     op_b = MBW'(d_py_by); end
      STEP_O4A:  begin op_a = MAW'(aby);     op_b = MBW'(d_fx_bx); end
      STEP_O4B:  begin op_a = MAW'(bax);     op_b = MBW'(d_fy_by); end
      STEP_DOTA: begin op_a = MAW'(d_px_ax); op_b = MBW'(abx);     end
      STEP_DOTB: begin op_a = MAW'(d_py_ay); op_b = MBW'(aby);     end
      STEP_NSQA: begin op_a = MAW'(abx);     op_b = MBW'(abx);     end
      STEP_NSQB: begin op_a = MAW'(aby);     op_b = MBW'(aby);     end
      STEP_NUMX: begin op_a = MAW'(abx);     op_b = dot_q;         end
      STEP_NUMY: begin op_a = MAW'(aby);     op_b = dot_q;         end
      STEP_DXL:  begin op_a = $signed(MAW'(m_x[16:0]));  op_b = $signed(MBW'(m_x)); end
      STEP_DXH:  begin op_a = $signed(MAW'(m_x >> 17));  op_b = $signed(MBW'(m_x)); end
      STEP_DYL:  begin op_a = $signed(MAW'(m_y[16:0]));  op_b = $signed(MBW'(m_y)); end
      STEP_DYH:  begin op_a = $signed(MAW'(m_y >> 17));  op_b = $signed(MBW'(m_y)); end
      default:   begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod      = op_a * op_b;
  assign cross_val = acc_q + prod[36:0];
  assign prod_w    = D2W'(prod);

  always_comb begin
    if (cross_val == '0) begin
      ori_new = ORI_COL;
    end else if (!cross_val[36]) begin
      ori_new = ORI_POS;
    end else begin
      ori_new = ORI_NEG;
    end
  end

  assign seg_hit = ((ori_q[0] != ori_q[1]) && (ori_q[2] != ori_q[3]))
                || ((ori_q[0] == ORI_COL) && in_box(p_x_q, p_y_q, a_x, a_y, f_x_q, f_y_q))
                || ((ori_q[1] == ORI_COL) && in_box(p_x_q, p_y_q, b_x, b_y, f_x_q, f_y_q))
                || ((ori_q[2] == ORI_COL) && in_box(a_x, a_y, p_x_q, p_y_q, b_x, b_y))
                || ((ori_q[3] == ORI_COL) && in_box(a_x, a_y, f_x_q, f_y_q, b_x, b_y));

  // dividers for the projected offsets
  assign neg_x  = -num_x_q;
  assign neg_y  = -num_y_q;
  assign dnum_x = {(num_x_q[NUMW-1] ? neg_x[52:0] : num_x_q[52:0]), {FRAC_BITS{1'b0}}};
  assign dnum_y = {(num_y_q[NUMW-1] ? neg_y[52:0] : num_y_q[52:0]), {FRAC_BITS{1'b0}}};

  rsnh_div #(.QW(QW), .DW(DW)) u_div_x (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(dnum_x), .den_i(nsq_q[DW-1:0]),
    .busy_o(busy_x), .quo_o(quo_x), .rem_nz_o(rnz_x)
  );

  rsnh_div #(.QW(QW), .DW(DW)) u_div_y (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(dnum_y), .den_i(nsq_q[DW-1:0]),
    .busy_o(busy_y), .quo_o(quo_y), .rem_nz_o(rnz_y)
  );

  // floor of signed quotient
  assign qs_x = num_x_q[NUMW-1] ? -($signed(CW'(quo_x)) + $signed(CW'(rnz_x)))
                                : $signed(CW'(quo_x));
  assign qs_y = num_y_q[NUMW-1] ? -($signed(CW'(quo_y)) + $signed(CW'(rnz_y)))
                                : $signed(CW'(quo_y));

  // control
  assign n_seg    = (NW'(count_q) > NW'(MAX_SEGMENTS)) ? NW'(MAX_SEGMENTS) : NW'(count_q);
  assign more_seg = (NW'(cnt_q) + NW'(1)) < n_seg;
  assign req_fire = req_i.valid && req_ready;
  assign slot_ext = (AW + SLOT_W)'(req_i.slot);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire && (req_i.op == OP_QUERY)) begin
          state_d = (n_seg == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ:  state_d = ST_CROSS;
      ST_CROSS: state_d = (step_q == STEP_NSQB) ? ST_TEST : ST_CROSS;
      ST_TEST: begin
        priority if (!seg_hit) begin
          state_d = ST_NEXT;
        end else if ((nsq_q == '0) || (dot_q <= 37'sd0) || (dot_q >= nsq_q)) begin
          state_d = ST_DIST;
        end else begin
          state_d = ST_NUM;
        end
      end
      ST_NUM:    state_d = (step_q == STEP_NUMY) ? ST_DSTART : ST_NUM;
      ST_DSTART: state_d = ST_DIV;
      ST_DIV:    state_d = (!busy_x && !busy_y) ? ST_DIST : ST_DIV;
      ST_DIST:   state_d = (step_q == STEP_DYH) ? ST_CMP : ST_DIST;
      ST_CMP:    state_d = ST_NEXT;
      ST_NEXT:   state_d = more_seg ? ST_READ : ST_DONE;
      ST_DONE:   state_d = (!rsp_valid_q || rsp_o.ready) ? ST_IDLE : ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE:   req_ready = 1'b1;
      ST_DSTART: div_start = 1'b1;
      default: begin
        req_ready = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    if ((state_q == ST_DONE) && (!rsp_valid_q || rsp_o.ready)) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      count_q     <= '0;
      best_hit_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid) begin
        count_q <= cfg_i.data;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q      <= '0;
          best_hit_q <= 1'b0;
        end
        ST_READ:  step_q <= STEP_O1A;
        ST_TEST:  step_q <= (state_d == ST_NUM) ? STEP_NUMX : STEP_DXL;
        ST_DIV:   step_q <= STEP_DXL;
        ST_CROSS, ST_NUM, ST_DIST: step_q <= step_q + 5'd1;
        ST_CMP: begin
          if (!best_hit_q || (d2_q < best_d2_q)) begin
            best_hit_q <= 1'b1;
          end
        end
        ST_NEXT:  cnt_q <= cnt_q + CNW'(1);
        default: begin
        end
      endcase
    end
  end

  // segment table
  always_ff @(posedge clk_i) begin
    if (req_fire && (req_i.op == OP_LOAD) &&
        (slot_ext < (AW + SLOT_W)'(MAX_SEGMENTS))) begin
      mem[slot_ext[AW-1:0]] <= {req_i.second_y, req_i.second_x, req_i.first_y, req_i.first_x};
    end
    if (state_q == ST_READ) begin
      rd_q <= mem[cnt_q[AW-1:0]];
    end
  end

  assign sat_x = (best_x_q > SAT_HI) ? OUT_W'(SAT_HI) :
                 (best_x_q < SAT_LO) ? OUT_W'(SAT_LO) : OUT_W'(best_x_q);
  assign sat_y = (best_y_q > SAT_HI) ? OUT_W'(SAT_HI) :
                 (best_y_q < SAT_LO) ? OUT_W'(SAT_LO) : OUT_W'(best_y_q);

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          p_x_q <= req_i.first_x;
          p_y_q <= req_i.first_y;
          f_x_q <= req_i.second_x;
          f_y_q <= req_i.second_y;
        end
      end
      ST_CROSS: begin
        if (!step_q[0]) begin
          acc_q <= prod[36:0];
        end else if (step_q == STEP_DOTB) begin
          dot_q <= cross_val;
        end else if (step_q == STEP_NSQB) begin
          nsq_q <= cross_val;
        end else begin
          ori_q[step_q[2:1]] <= ori_new;
        end
      end
      ST_TEST: begin
        if ((nsq_q == '0) || (dot_q <= 37'sd0)) begin
          cx_q <= CW'(a_x) <<< FRAC_BITS;
          cy_q <= CW'(a_y) <<< FRAC_BITS;
        end else begin
          cx_q <= CW'(b_x) <<< FRAC_BITS;
          cy_q <= CW'(b_y) <<< FRAC_BITS;
        end
      end
      ST_NUM: begin
        if (step_q == STEP_NUMX) begin
          num_x_q <= prod[NUMW-1:0];
        end else begin
          num_y_q <= prod[NUMW-1:0];
        end
      end
      ST_DIV: begin
        cx_q <= (CW'(a_x) <<< FRAC_BITS) + qs_x;
        cy_q <= (CW'(a_y) <<< FRAC_BITS) + qs_y;
      end
      ST_DIST: begin
        priority case (step_q)
          STEP_DXL:           d2_q <= prod_w;
          STEP_DYL:           d2_q <= d2_q + prod_w;
          STEP_DXH, STEP_DYH: d2_q <= d2_q + (prod_w <<< 17);
          default:            d2_q <= d2_q;
        endcase
      end
      ST_CMP: begin
        if (!best_hit_q || (d2_q < best_d2_q)) begin
          best_d2_q <= d2_q;
          best_x_q  <= cx_q;
          best_y_q  <= cy_q;
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_hit_q <= best_hit_q;
          rsp_x_q   <= best_hit_q ? sat_x : '0;
          rsp_y_q   <= best_hit_q ? sat_y : '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign req_i.ready  = req_ready;
  assign cfg_i.ready  = 1'b1;
  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.hit    = rsp_hit_q;
  assign rsp_o.near_x = rsp_x_q;
  assign rsp_o.near_y = rsp_y_q;

  a_div_idle_at_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DSTART) |-> (!busy_x && !busy_y))
    else $error("divider started while busy");

  a_div_runs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DSTART) |=> (busy_x && busy_y))
    else $error("divider did not start");

  a_read_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (NW'(cnt_q) < n_seg))
    else $error("table read beyond segment count");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_hit_q) |-> ((rsp_x_q == '0) && (rsp_y_q == '0)))
    else $error("miss result carries a point");

endmodule
